@@ rtl/core/ufp_pkg.sv @@
// shared types and constants for the uart frame parser with fletcher check
package ufp_pkg;

    typedef logic [1:0] op_t;
    typedef logic [2:0] phase_t;

    localparam op_t OP_BYTE = 2'd0;
    localparam op_t OP_ACK  = 2'd1;
    localparam op_t OP_READ = 2'd2;

    localparam phase_t PH_HUNT = 3'd0;
    localparam phase_t PH_LEN  = 3'd1;
    localparam phase_t PH_ID   = 3'd2;
    localparam phase_t PH_DATA = 3'd3;
    localparam phase_t PH_SUMA = 3'd4;
    localparam phase_t PH_SUMB = 3'd5;

    localparam logic [7:0] FRAME_OVERHEAD = 8'd5;
    localparam logic [7:0] START_RESET    = 8'd153;

    typedef struct packed {
        phase_t      phase;
        logic        held;
        logic [15:0] err;
        logic [7:0]  exp_len;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [7:0]  fill;
        logic [7:0]  ident;
    } state_t;

    typedef struct packed {
        logic done;
        logic store_wr;
    } step_flags_t;

endpackage

@@ rtl/core/ufp_step.sv @@
// next-state logic of the frame parser for one transaction
module ufp_step
(
    input  ufp_pkg::state_t      state_cur,
    input  ufp_pkg::op_t         op,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           start_byte,
    output ufp_pkg::state_t      state_next,
    output ufp_pkg::step_flags_t flags
);
    import ufp_pkg::*;

    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;
    logic [7:0] fill_inc;

    assign sum_a_add = state_cur.sum_a + rx_byte;
    assign sum_b_add = state_cur.sum_b + sum_a_add;
    assign fill_inc  = state_cur.fill + 8'd1;

    always_comb
    begin
        state_next = state_cur;
        flags      = '0;
        unique case (op)
            OP_BYTE:
            begin
                unique case (state_cur.phase)
                    PH_HUNT:
                    begin
                        if (rx_byte == start_byte)
                        begin
                            state_next.phase = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        if (state_cur.held || (rx_byte < FRAME_OVERHEAD))
                        begin
                            state_next.err   = state_cur.err + 16'd1;
                            state_next.phase = PH_HUNT;
                        end
                        else
                        begin
                            state_next.exp_len = rx_byte - FRAME_OVERHEAD;
                            state_next.sum_a   = rx_byte;
                            state_next.sum_b   = rx_byte;
                            state_next.fill    = '0;
                            state_next.phase   = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        state_next.ident = rx_byte;
                        state_next.sum_a = sum_a_add;
                        state_next.sum_b = sum_b_add;
                        state_next.phase = (state_cur.exp_len == 8'd0) ? PH_SUMA : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        flags.store_wr   = 1'b1;
                        state_next.sum_a = sum_a_add;
                        state_next.sum_b = sum_b_add;
                        state_next.fill  = fill_inc;
                        if (fill_inc == state_cur.exp_len)
                        begin
                            state_next.phase = PH_SUMA;
                        end
                    end
                    PH_SUMA:
                    begin
                        if (rx_byte != state_cur.sum_a)
                        begin
                            state_next.err   = state_cur.err + 16'd1;
                            state_next.phase = PH_HUNT;
                        end
                        else
                        begin
                            state_next.phase = PH_SUMB;
                        end
                    end
                    PH_SUMB:
                    begin
                        state_next.phase = PH_HUNT;
                        if (rx_byte != state_cur.sum_b)
                        begin
                            state_next.err = state_cur.err + 16'd1;
                        end
                        else
                        begin
                            state_next.held = 1'b1;
                            flags.done      = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next.err   = state_cur.err + 16'd1;
                        state_next.phase = PH_HUNT;
                    end
                endcase
            end
            OP_ACK:
            begin
                state_next.held = 1'b0;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

@@ rtl/core/uart_frame_parser_fletcher_unit.sv @@
// top level of the uart frame parser with fletcher-style check (sums modulo 256) and payload buffer
// Each transaction is one received byte (op 0), an acknowledge of the held frame (op 1) or a
// payload read by index (op 2), and gives exactly one status result. A transaction is taken
// into an input register, goes through the parser update and the payload buffer port, and
// its result lands in the output register; a new transaction is taken every cycle while the
// output side does not stall. The payload buffer holds PAYLOAD_DEPTH bytes with one write
// and one registered read port; it has no reset, and reading an entry never written returns
// an undefined byte. The start byte register resets to 153 and may be written only while no
// transaction is in flight.
module uart_frame_parser_fletcher_unit
#(
    parameter int PAYLOAD_DEPTH = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ufp_pkg::op_t  op,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    read_index,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          frame_held,
    output logic [7:0]    message_id,
    output logic [7:0]    payload_count,
    output logic [15:0]   error_total,
    output logic [7:0]    read_byte,
    output logic          frame_done,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);
    import ufp_pkg::*;

    localparam int         IDX_W    = $clog2(PAYLOAD_DEPTH);
    localparam logic [8:0] DEPTH_W9 = 9'(PAYLOAD_DEPTH);

    logic [7:0]  start_byte_reg;
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [7:0]  s1_rx_reg;
    logic [7:0]  s1_index_reg;
    logic        out_valid_reg;
    logic        frame_done_reg;
    logic [7:0]  read_byte_reg;
    state_t      state_reg;
    state_t      state_next;
    step_flags_t flags;
    logic        advance;
    logic        accept;
    logic        store_wr;
    logic        read_hit;

    logic [7:0]  payload_mem [PAYLOAD_DEPTH];

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    ufp_step u_step
    (
        .state_cur  (state_reg),
        .op         (s1_op_reg),
        .rx_byte    (s1_rx_reg),
        .start_byte (start_byte_reg),
        .state_next (state_next),
        .flags      (flags)
    );

    assign store_wr = flags.store_wr && ({1'b0, state_reg.fill} < DEPTH_W9);
    assign read_hit = (s1_op_reg == OP_READ) && ({1'b0, s1_index_reg} < DEPTH_W9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_byte_reg <= cfg_data;
        end
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op;
            s1_rx_reg    <= rx_byte;
            s1_index_reg <= read_index;
        end
        if (advance)
        begin
            frame_done_reg <= flags.done;
        end
    end

    // payload buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (advance && store_wr)
        begin
            payload_mem[state_reg.fill[IDX_W-1:0]] <= s1_rx_reg;
        end
        if (advance)
        begin
            read_byte_reg <= read_hit ? payload_mem[s1_index_reg[IDX_W-1:0]] : 8'd0;
        end
    end

    // parser state only moves together with the result register
    assign out_valid     = out_valid_reg;
    assign frame_held    = state_reg.held;
    assign message_id    = state_reg.ident;
    assign payload_count = state_reg.exp_len;
    assign error_total   = state_reg.err;
    assign read_byte     = read_byte_reg;
    assign frame_done    = frame_done_reg;

endmodule
